@@ src/dane_owner_name_checker_top_macros.svh @@
// ---------------------------------------------------------------------------
// dane owner name checker assertion macros
// concurrent assertion helpers on i_clk, with and without reset masking
// ---------------------------------------------------------------------------
`ifndef DANE_OWNER_NAME_CHECKER_TOP_MACROS_SVH
`define DANE_OWNER_NAME_CHECKER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked only out of reset
`define DONC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("dane owner name checker assertion failed");

// checked during reset as well
`define DONC_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("dane owner name checker reset assertion failed");

`else

`define DONC_ASSERT(lbl, prop)
`define DONC_ASSERT_RST(lbl, prop)

`endif

`endif

@@ src/donc_pkg.sv @@
// ---------------------------------------------------------------------------
// donc_pkg
// shared types, constants and tail candidate text for the owner name checker
// ---------------------------------------------------------------------------
`default_nettype none

package donc_pkg;

    typedef enum logic [2:0] {
        PH_START    = 3'd0,
        PH_PORT     = 3'd1,
        PH_TLSA_TL  = 3'd2,
        PH_TLSA_END = 3'd3,
        PH_HEX      = 3'd4,
        PH_SMI_TL   = 3'd5,
        PH_SMI_END  = 3'd6
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [16:0] port_acc;
        logic [5:0]  hex_cnt;
        logic [3:0]  suf_pos;
        logic [3:0]  suf_flags;
        logic [3:0]  tail_len;
        logic        failed;
    } t_name_state;

    localparam t_name_state NAME_STATE_RST = '{
        phase:     PH_START,
        port_acc:  17'd0,
        hex_cnt:   6'd0,
        suf_pos:   4'd0,
        suf_flags: 4'hf,
        tail_len:  4'd0,
        failed:    1'b0
    };

    // configuration register indexes
    localparam logic CFG_IDX_MODE   = 1'b0;
    localparam logic CFG_IDX_ENABLE = 1'b1;

    localparam logic [16:0] PORT_MAX        = 17'd65535;
    localparam logic [16:0] PORT_SAT        = 17'd65536;
    localparam logic [5:0]  HASH_DIGITS     = 6'd56;
    localparam logic [5:0]  HEX_CNT_SAT     = 6'd63;
    localparam logic [3:0]  CNT4_SAT        = 4'd15;
    localparam logic [3:0]  TLSA_TAIL_MIN   = 4'd6;
    localparam logic [3:0]  SMIMEA_TAIL_MIN = 4'd11;

    localparam logic [7:0] CH_UNDERSCORE = 8'h5f;
    localparam logic [7:0] CH_DOT        = 8'h2e;
    localparam logic [7:0] CH_NUL        = 8'h00;

    // candidate tails, right-justified, first character in the top byte used
    localparam int unsigned N_CAND = 4;
    localparam logic [87:0] CAND_TEXT [N_CAND] = '{
        88'("_tcp."), 88'("_udp."), 88'("_sctp."), 88'("_smimecert.")
    };
    localparam logic [3:0] CAND_LEN [N_CAND] = '{4'd5, 4'd5, 4'd6, 4'd11};

    // character at position pos of candidate k, valid only while pos < length
    function automatic logic [7:0] cand_char(input int unsigned k, input logic [3:0] pos);
        int unsigned idx;
        logic [7:0]  ch;
        ch = 8'h00;
        if (pos < CAND_LEN[k]) begin
            idx = (int'(CAND_LEN[k]) - 1 - int'(pos)) * 8;
            ch  = CAND_TEXT[k][idx +: 8];
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

@@ src/donc_suffix.sv @@
// ---------------------------------------------------------------------------
// donc_suffix
// tail prefix matcher: drops candidates that disagree at the current position
// ---------------------------------------------------------------------------
`default_nettype none

module donc_suffix
    import donc_pkg::*;
(
    input  wire logic [7:0] i_char,
    input  wire logic [3:0] i_pos,
    input  wire logic [3:0] i_flags,
    output logic      [3:0] o_flags
);

    always_comb begin
        o_flags = i_flags;
        for (int unsigned k = 0; k < N_CAND; k++) begin
            if ((i_pos < CAND_LEN[k]) && (i_char != cand_char(k, i_pos))) begin
                o_flags[k] = 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

@@ src/donc_core.sv @@
// ---------------------------------------------------------------------------
// donc_core
// per-character state update and result evaluation for one owner name word
// ---------------------------------------------------------------------------
`default_nettype none

module donc_core
    import donc_pkg::*;
(
    input  wire t_name_state  i_state,
    input  wire logic [7:0]   i_char,
    input  wire logic         i_mode,
    input  wire logic         i_enabled,
    output t_name_state       o_state,
    output logic              o_ok,
    output logic [15:0]       o_port
);

    logic [3:0]  suf_flags_upd;
    logic [20:0] acc_x10;
    logic        is_dec;
    logic        is_hex;
    t_phase      ph;
    logic        first;

    donc_suffix u_suffix (
        .i_char  (i_char),
        .i_pos   (i_state.suf_pos),
        .i_flags (i_state.suf_flags),
        .o_flags (suf_flags_upd)
    );

    assign is_dec = (i_char >= 8'h30) && (i_char <= 8'h39);
    assign is_hex = is_dec || ((i_char >= 8'h61) && (i_char <= 8'h66))
                    || ((i_char >= 8'h41) && (i_char <= 8'h46));

    // acc * 10 + digit as shift-and-add
    assign acc_x10 = ({4'b0, i_state.port_acc} << 3) + ({4'b0, i_state.port_acc} << 1)
                     + {17'b0, i_char[3:0]};

    always_comb begin
        o_state = i_state;
        first   = (i_state.phase == PH_START);
        ph      = i_state.phase;
        if (first) begin
            ph = i_mode ? PH_HEX : PH_PORT;
        end
        o_state.phase = ph;

        case (ph)
            PH_PORT: begin
                if (first) begin
                    if (i_char != CH_UNDERSCORE) o_state.failed = 1'b1;
                end else if (!i_state.failed) begin
                    if (is_dec) begin
                        o_state.port_acc = (acc_x10 > {4'b0, PORT_MAX}) ? PORT_SAT
                                                                         : acc_x10[16:0];
                    end else if ((i_char == CH_DOT) && (i_state.port_acc != 17'd0)
                                 && (i_state.port_acc <= PORT_MAX)) begin
                        o_state.phase = PH_TLSA_TL;
                    end else begin
                        o_state.failed = 1'b1;
                    end
                end
            end
            PH_HEX: begin
                if (!i_state.failed) begin
                    if (is_hex) begin
                        if (i_state.hex_cnt < HEX_CNT_SAT)
                            o_state.hex_cnt = i_state.hex_cnt + 6'd1;
                    end else if ((i_char == CH_DOT) && (i_state.hex_cnt == HASH_DIGITS)) begin
                        o_state.phase = PH_SMI_TL;
                    end else begin
                        o_state.failed = 1'b1;
                    end
                end
            end
            PH_TLSA_TL, PH_SMI_TL: begin
                if (i_char == CH_NUL) begin
                    o_state.phase = (ph == PH_TLSA_TL) ? PH_TLSA_END : PH_SMI_END;
                end else begin
                    o_state.suf_flags = suf_flags_upd;
                    if (i_state.suf_pos < CNT4_SAT) o_state.suf_pos = i_state.suf_pos + 4'd1;
                    if (i_state.tail_len < CNT4_SAT)
                        o_state.tail_len = i_state.tail_len + 4'd1;
                end
            end
            default: begin
            end
        endcase
    end

    // verdict from the state after this character
    always_comb begin
        o_ok   = 1'b0;
        o_port = 16'd0;
        if (!o_state.failed) begin
            if ((o_state.phase == PH_TLSA_TL) || (o_state.phase == PH_TLSA_END)) begin
                o_ok = (o_state.tail_len >= TLSA_TAIL_MIN) && (o_state.suf_flags[2:0] != 3'b0);
                if (o_ok) o_port = o_state.port_acc[15:0];
            end else if ((o_state.phase == PH_SMI_TL) || (o_state.phase == PH_SMI_END)) begin
                o_ok = (o_state.tail_len >= SMIMEA_TAIL_MIN) && o_state.suf_flags[3];
            end
        end
        if (!i_enabled) begin
            o_ok   = 1'b1;
            o_port = 16'd0;
        end
    end

endmodule

`default_nettype wire

@@ src/dane_owner_name_checker_top.sv @@
// ---------------------------------------------------------------------------
// dane_owner_name_checker_top
// streaming policy check of tlsa / smimea owner names, one character a word
// ---------------------------------------------------------------------------
// the owner name arrives one character per input word, with i_last_char set
// on the final one; only that word produces a result word (name_ok and the
// decoded port). the block takes one word every cycle unless the output
// stalls; the per-name state update, including the multiply by ten of the
// port digits, is combinational; the verdict is on the output register in the
// cycle after the flagged word is accepted. check_mode is latched into the
// name state by the first character, check_enabled is looked at on the last
// one. configuration should only be written while no name is in flight.
`default_nettype none

`include "dane_owner_name_checker_top_macros.svh"

module dane_owner_name_checker_top
    import donc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write port
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic        i_cfg_data,
    // character stream in
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_name_char,
    input  wire logic        i_last_char,
    // verdict out
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_name_ok,
    output logic [15:0]      o_port_number
);

    // configuration registers
    logic r_mode;
    logic r_enabled;

    // running name state
    t_name_state r_state;
    t_name_state n_state;

    // result register
    logic        r_out_valid;
    logic        n_out_valid;
    logic        r_ok;
    logic [15:0] r_port;

    logic        core_ok;
    logic [15:0] core_port;
    logic        in_acc;

    donc_core u_core (
        .i_state   (r_state),
        .i_char    (i_name_char),
        .i_mode    (r_mode),
        .i_enabled (r_enabled),
        .o_state   (n_state),
        .o_ok      (core_ok),
        .o_port    (core_port)
    );

    // the result register frees up in the same cycle it is read out
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_acc     = i_in_valid && o_in_ready;

    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        if (in_acc && i_last_char) n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b0;
            r_enabled   <= 1'b0;
            r_state     <= NAME_STATE_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_IDX_MODE:   r_mode    <= i_cfg_data;
                    CFG_IDX_ENABLE: r_enabled <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            // name state restarts after the flagged character
            if (in_acc) r_state <= i_last_char ? NAME_STATE_RST : n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_acc && i_last_char) begin
            r_ok   <= core_ok;
            r_port <= core_port;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_name_ok     = r_ok;
    assign o_port_number = r_port;

    // a failing name never reports a port
    `DONC_ASSERT(a_fail_no_port, (r_out_valid && !r_ok) |-> (r_port == 16'd0))
    // the flagged word always lands in the result register
    `DONC_ASSERT(a_last_gives_result, (in_acc && i_last_char) |=> r_out_valid)
    // an unflagged word never creates a result
    `DONC_ASSERT(a_mid_no_result, (in_acc && !i_last_char && !r_out_valid) |=> !r_out_valid)
    // reset empties the result register
    `DONC_ASSERT_RST(a_reset_empty, !i_rst_n |=> !r_out_valid)

endmodule

`default_nettype wire

@@ tb/tb_donc_verdict_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_donc_verdict_pkg
// owner name verdict predictor and scoreboard for the checker testbench
// ---------------------------------------------------------------------------
package tb_donc_verdict_pkg;
    import donc_pkg::*;

    typedef struct {
        logic        ok;
        logic [15:0] port;
    } name_verdict_t;

    class name_verdict_board;
        name_verdict_t verdicts_due[$];
        bit            mode_reg;
        bit            enable_reg;
        t_phase        phase;
        logic [16:0]   port_acc;
        logic [5:0]    hex_cnt;
        logic [3:0]    suf_pos;
        logic [3:0]    suf_flags;
        logic [3:0]    tail_len;
        bit            failed;
        string         tails [4];
        int unsigned   faults;
        int unsigned   verdicts_seen;

        function new();
            tails         = '{"_tcp.", "_udp.", "_sctp.", "_smimecert."};
            mode_reg      = 1'b0;
            enable_reg    = 1'b0;
            faults        = 0;
            verdicts_seen = 0;
            clear_name();
        endfunction

        function void clear_name();
            phase     = PH_START;
            port_acc  = '0;
            hex_cnt   = '0;
            suf_pos   = '0;
            suf_flags = 4'hf;
            tail_len  = '0;
            failed    = 1'b0;
        endfunction

        function void set_reg(logic idx, logic data);
            if (idx == CFG_IDX_MODE) begin
                mode_reg = data;
            end else begin
                enable_reg = data;
            end
        endfunction

        function bit is_dec(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit is_hex(logic [7:0] c);
            return is_dec(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
        endfunction

        // drop every candidate that disagrees at this tail position
        function void tail_char(logic [7:0] c);
            for (int k = 0; k < 4; k++) begin
                if (suf_pos < tails[k].len() && c != 8'(tails[k][suf_pos]))
                    suf_flags[k] = 1'b0;
            end
            if (suf_pos != CNT4_SAT) suf_pos++;
            if (tail_len != CNT4_SAT) tail_len++;
        endfunction

        function void port_char(logic [7:0] c);
            int unsigned acc10;
            if (failed) return;
            if (is_dec(c)) begin
                acc10    = port_acc * 10 + (c - "0");
                port_acc = (acc10 > PORT_MAX) ? PORT_SAT : acc10[16:0];
            end else if (c == CH_DOT && port_acc >= 1 && port_acc <= PORT_MAX) begin
                phase = PH_TLSA_TL;
            end else begin
                failed = 1'b1;
            end
        endfunction

        function void hex_char(logic [7:0] c);
            if (failed) return;
            if (is_hex(c)) begin
                if (hex_cnt != HEX_CNT_SAT) hex_cnt++;
            end else if (c == CH_DOT && hex_cnt == HASH_DIGITS) begin
                phase = PH_SMI_TL;
            end else begin
                failed = 1'b1;
            end
        endfunction

        // one accepted character; the flagged one queues a verdict
        function void note_char(logic [7:0] c, logic last);
            name_verdict_t v;
            case (phase)
                PH_START: begin
                    if (mode_reg) begin
                        phase = PH_HEX;
                        hex_char(c);
                    end else begin
                        phase = PH_PORT;
                        if (c != CH_UNDERSCORE) failed = 1'b1;
                    end
                end
                PH_PORT: port_char(c);
                PH_TLSA_TL: begin
                    if (c == CH_NUL) phase = PH_TLSA_END;
                    else tail_char(c);
                end
                PH_HEX: hex_char(c);
                PH_SMI_TL: begin
                    if (c == CH_NUL) phase = PH_SMI_END;
                    else tail_char(c);
                end
                default: ;
            endcase
            if (!last) return;
            v.ok   = 1'b0;
            v.port = '0;
            if (!failed) begin
                if (phase == PH_TLSA_TL || phase == PH_TLSA_END) begin
                    v.ok = (tail_len >= TLSA_TAIL_MIN) && (suf_flags[2:0] != 3'b000);
                    if (v.ok) v.port = port_acc[15:0];
                end else if (phase == PH_SMI_TL || phase == PH_SMI_END) begin
                    v.ok = (tail_len >= SMIMEA_TAIL_MIN) && suf_flags[3];
                end
            end
            if (!enable_reg) begin
                v.ok   = 1'b1;
                v.port = '0;
            end
            verdicts_due.push_back(v);
            clear_name();
        endfunction

        function void fault(string msg);
            faults++;
            if (faults <= 10) $display("mismatch %0d: %s", faults, msg);
        endfunction

        function void check_verdict(logic ok, logic [15:0] port);
            name_verdict_t v;
            verdicts_seen++;
            if (verdicts_due.size() == 0) begin
                fault($sformatf("verdict ok=%0b port=%0d with none due", ok, port));
                return;
            end
            v = verdicts_due.pop_front();
            if (ok !== v.ok || port !== v.port)
                fault($sformatf("verdict %0d: expected ok=%0b port=%0d, got ok=%0b port=%0d",
                                verdicts_seen, v.ok, v.port, ok, port));
        endfunction
    endclass

endpackage

@@ tb/tb_dane_owner_name_checker_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_dane_owner_name_checker_top
// self-checking bench for the dane owner name checker
// ---------------------------------------------------------------------------
// owner names are streamed in one character per word; every accepted word is
// fed to a scoreboard that predicts the verdict of each flagged last word,
// and every verdict word taken from the block is checked against the oldest
// prediction. directed names come first, then random phases under all four
// register settings, with random idling on both channels, a long output
// hold-off and a mid-phase drain.
// ---------------------------------------------------------------------------
module tb_dane_owner_name_checker_top;
    import donc_pkg::*;
    import tb_donc_verdict_pkg::*;

    localparam int unsigned IDLE_PCT      = 22;
    localparam int unsigned STALL_LIMIT   = 2000;
    localparam int unsigned HOLD_CYCLES   = 200;
    localparam int unsigned SETTLE_CYCLES = 3;
    localparam int unsigned PHASE_WORDS   = 40;
    localparam int unsigned PHASE_NAMES   = 1;
    // register setting per random phase, bit p belongs to phase p
    localparam bit [7:0] PLAN_MODE = 8'b1100_1010;
    localparam bit [7:0] PLAN_EN   = 8'b0111_0011;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic        i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_name_char;
    logic        i_last_char;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_name_ok;
    logic [15:0] o_port_number;

    name_verdict_board board;
    logic [7:0]        name_buf[$];
    bit                tx_steady     = 1'b0;
    bit                rx_steady     = 1'b0;
    int unsigned       rx_hold       = 0;
    int unsigned       words_sent    = 0;
    int unsigned       names_sent    = 0;
    int unsigned       settings_used = 0;
    int unsigned       stall_cycles  = 0;

    dane_owner_name_checker_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_name_char   (i_name_char),
        .i_last_char   (i_last_char),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_name_ok     (o_name_ok),
        .o_port_number (o_port_number)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // verdict checking and the watchdog on cycles with no word moving
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) board.check_verdict(o_name_ok, o_port_number);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                stall_cycles = 0;
            end else if (stall_cycles == STALL_LIMIT) begin
                $display("watchdog: no word accepted for %0d cycles", STALL_LIMIT);
                $display("FAILURE");
                $finish;
            end else begin
                stall_cycles++;
            end
        end
    end

    // receiver: random back-pressure, or a counted hold-off when asked for
    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold != 0) begin
                i_out_ready <= 1'b0;
                repeat (rx_hold) @(posedge i_clk);
                rx_hold = 0;
            end else begin
                i_out_ready <= rx_steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // offer one word, idling first at random, and hold it until taken
    task automatic send_word(input logic [7:0] c, input logic last);
        while (!tx_steady && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_name_char <= c;
        i_last_char <= last;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_char(c, last);
        words_sent++;
    endtask

    task automatic send_name();
        for (int i = 0; i < name_buf.size(); i++)
            send_word(name_buf[i], i == name_buf.size() - 1);
        names_sent++;
        name_buf.delete();
    endtask

    // stop offering and wait for every predicted verdict, then let it settle
    task automatic drain_verdicts();
        i_in_valid <= 1'b0;
        while (board.verdicts_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // both registers are rewritten, only with no name in flight
    task automatic apply_setting(input bit mode, input bit en);
        drain_verdicts();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_IDX_MODE;
        i_cfg_data  <= mode;
        @(posedge i_clk);
        board.set_reg(CFG_IDX_MODE, mode);
        i_cfg_index <= CFG_IDX_ENABLE;
        i_cfg_data  <= en;
        @(posedge i_clk);
        board.set_reg(CFG_IDX_ENABLE, en);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++) name_buf.push_back(s[i]);
    endfunction

    function automatic void add_hex(input int n);
        string digits = "0123456789abcdefABCDEF";
        for (int i = 0; i < n; i++) name_buf.push_back(digits[$urandom_range(21)]);
    endfunction

    function automatic void add_label(input int n);
        string chars = "abcdefghijklmnopqrstuvwxyz0123456789-_.";
        for (int i = 0; i < n; i++) name_buf.push_back(chars[$urandom_range(38)]);
    endfunction

    function automatic void add_junk(input int n);
        for (int i = 0; i < n; i++) name_buf.push_back(8'($urandom_range(255)));
    endfunction

    // sometimes end the text early with a zero byte and trailing rubbish
    function automatic void add_ending();
        if ($urandom_range(4) == 0) begin
            name_buf.push_back(CH_NUL);
            add_junk($urandom_range(3));
        end
    endfunction

    // mostly legal ports, with the extremes, overflow, zero and no digits
    function automatic void add_port();
        int unsigned pick;
        int unsigned port;
        pick = $urandom_range(11);
        case (pick)
            0:       port = 1;
            1:       port = 65535;
            2:       port = $urandom_range(65536, 99999);
            3:       port = $urandom_range(100000, 9999999);
            4:       port = 0;
            5, 6:    port = $urandom_range(1, 999);
            default: port = $urandom_range(1, 65535);
        endcase
        if ($urandom_range(7) == 0) name_buf.push_back("0");
        if (pick != 4 || $urandom_range(1) == 1) add_text($sformatf("%0d", port));
    endfunction

    function automatic void add_tlsa();
        add_text("_");
        add_port();
        add_text(".");
        case ($urandom_range(2))
            0:       add_text("_tcp.");
            1:       add_text("_udp.");
            default: add_text("_sctp.");
        endcase
        add_label($urandom_range(14));
        add_ending();
    endfunction

    function automatic void add_smimea();
        int unsigned pick;
        int          n;
        pick = $urandom_range(9);
        case (pick)
            0:       n = 55;
            1:       n = 57;
            2:       n = $urandom_range(58, 80);
            3:       n = $urandom_range(1, 54);
            default: n = 56;
        endcase
        add_hex(n);
        add_text("._smimecert.");
        add_label($urandom_range(6));
        add_ending();
    endfunction

    // mostly well-formed names for the current form, the rest broken or noise
    function automatic void add_random_name(input bit mode);
        int unsigned r;
        int unsigned at;
        r = $urandom_range(99);
        if (r >= 90) begin
            add_junk($urandom_range(1, 12));
        end else begin
            if (mode ^ (r >= 60 && r < 70)) add_smimea();
            else add_tlsa();
            if (r >= 70 && r < 82) begin
                at           = $urandom_range(name_buf.size() - 1);
                name_buf[at] = 8'($urandom_range(255));
            end else if (r >= 82) begin
                repeat ($urandom_range(name_buf.size() - 1)) void'(name_buf.pop_back());
            end
        end
    endfunction

    initial begin
        int unsigned phase_words;
        int unsigned phase_names;

        board       = new();
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_IDX_MODE;
        i_cfg_data  <= 1'b0;
        i_in_valid  <= 1'b0;
        i_name_char <= 8'h00;
        i_last_char <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: check off, so anything passes with no port
        add_text("_443._tcp.example");
        send_name();
        name_buf.push_back(8'hff);
        send_name();

        // tlsa form, check on
        apply_setting(1'b0, 1'b1);
        add_text("_443._tcp.example");
        send_name();
        add_text("_1._udp.x");
        send_name();
        add_text("_65535._sctp.");
        send_name();
        // port overflow, port zero, no digits, tail too short
        add_text("_65536._tcp.abc");
        send_name();
        add_text("_0._tcp.abc");
        send_name();
        add_text("_._tcp.abc");
        send_name();
        add_text("_25._tcp.");
        send_name();
        // zero byte inside the tail, then ignored bytes
        add_text("_25._tcp.a");
        name_buf.push_back(CH_NUL);
        add_text("zz");
        name_buf.push_back(8'h80);
        send_name();
        // zero byte before the tail
        add_text("_25");
        name_buf.push_back(CH_NUL);
        add_text("._tcp.abc");
        send_name();
        add_text("x25._tcp.abc");
        send_name();
        // name ending before its tail
        add_text("_25");
        send_name();
        add_text("_25._tls.abcd");
        send_name();
        name_buf.push_back(8'hff);
        send_name();
        // long tail, saturating position and length
        add_text("_80._tcp.abcdefghijklmnopqrst");
        send_name();

        // smimea form, check on
        apply_setting(1'b1, 1'b1);
        add_hex(56);
        add_text("._smimecert.");
        send_name();
        add_hex(55);
        add_text("._smimecert.x");
        send_name();
        add_hex(57);
        add_text("._smimecert.x");
        send_name();
        // hex count saturating
        add_hex(70);
        add_text("._smimecert.x");
        send_name();
        add_hex(56);
        add_text("x_smimecert.x");
        send_name();
        add_hex(56);
        add_text("._smimecert");
        send_name();
        add_hex(56);
        add_text("._smimecert.a");
        name_buf.push_back(CH_NUL);
        name_buf.push_back(8'hff);
        send_name();
        add_text("_443._tcp.example");
        send_name();
        name_buf.push_back(CH_NUL);
        send_name();

        // random phases over every setting; phase 4 runs with no idling,
        // phase 5 starts with a long receiver hold-off, phase 6 drains midway
        for (int p = 0; p < 8; p++) begin
            apply_setting(PLAN_MODE[p], PLAN_EN[p]);
            tx_steady   = (p == 4);
            rx_steady   = (p == 4);
            if (p == 5) rx_hold = HOLD_CYCLES;
            phase_words = words_sent;
            phase_names = names_sent;
            while (words_sent - phase_words < PHASE_WORDS ||
                   names_sent - phase_names < PHASE_NAMES ||
                   (p == 6 && names_sent - phase_names < 2)) begin
                if (p == 6 && names_sent - phase_names == 1) drain_verdicts();
                add_random_name(PLAN_MODE[p]);
                send_name();
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;

        drain_verdicts();
        if (board.verdicts_due.size() != 0)
            board.fault($sformatf("%0d verdicts never arrived", board.verdicts_due.size()));
        $display("checked %0d verdicts for %0d names in %0d words under %0d register settings",
                 board.verdicts_seen, names_sent, words_sent, settings_used);
        $display("tlsa and smimea forms, check off, saturation, zero bytes, hold-off and drain");
        if (board.faults == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", board.faults);
            $display("FAILURE");
        end
        $finish;
    end

endmodule
